### hw/rtl/rab_pkg.sv
// Shared types and constants for the RGBA alpha blend pixel block.
// Used by rab_coef, rab_lane and rgba_alpha_blend_pixel.
`default_nettype none

package rab_pkg;

  // Channel width and the full-scale channel value
  localparam int unsigned ChanW = 8;
  localparam int unsigned FullVal = 255;

  // Width of weight products (8 x 8 bits) and lane sums (fits 255 * 65025)
  localparam int unsigned WeightW = 16;
  localparam int unsigned NumW = 24;

  // Reciprocal of 65025: floor(x * DivSqMul / 2^DivSqShift) is exact for x < 2^24
  localparam int unsigned DivSqMulW = 25;
  localparam logic [DivSqMulW-1:0] DivSqMul = 25'd16909061;
  localparam int unsigned DivSqShift = 40;

  // Reciprocal of 255: floor(x * DivMul / 2^DivShift) is exact for x <= 65025
  localparam int unsigned DivMulW = 17;
  localparam logic [DivMulW-1:0] DivMul = 17'd65794;
  localparam int unsigned DivShift = 24;

  // Register load enables of the three pipeline stages
  typedef struct packed {
    logic ld_in;
    logic ld_num;
    logic ld_out;
  } stage_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/rab_coef.sv
// Weight and alpha path: source and destination weights, combined alpha.
// Depends on rab_pkg for widths, reciprocal constants and stage_ctl_t.
`default_nettype none

module rab_coef (
  input  wire                          clk_i,
  input  rab_pkg::stage_ctl_t          ctl_i,
  input  wire  [rab_pkg::ChanW-1:0]    src_alpha_i,
  input  wire  [rab_pkg::ChanW-1:0]    dst_alpha_i,
  output logic [rab_pkg::WeightW-1:0]  src_wt_o,
  output logic [rab_pkg::WeightW-1:0]  dst_wt_o,
  output logic [rab_pkg::ChanW-1:0]    alpha_o
);

  localparam int unsigned ProdW = rab_pkg::WeightW + rab_pkg::DivMulW;

  logic [rab_pkg::ChanW-1:0]   inv_sa;
  logic [rab_pkg::WeightW-1:0] src_wt_d, src_wt_q;
  logic [rab_pkg::WeightW-1:0] dst_wt_d, dst_wt_q;
  logic [rab_pkg::ChanW-1:0]   sa_q;
  logic [ProdW-1:0]            dst_prod;
  logic [rab_pkg::ChanW:0]     alpha_sum;
  logic [rab_pkg::ChanW-1:0]   alpha_d, alpha2_q, alpha3_q;

  // Weights: sa*255 for the source, da*(255-sa) for the destination
  always_comb begin
    inv_sa   = rab_pkg::ChanW'(rab_pkg::FullVal) - src_alpha_i;
    src_wt_d = rab_pkg::WeightW'(src_alpha_i) * rab_pkg::WeightW'(rab_pkg::FullVal);
    dst_wt_d = rab_pkg::WeightW'(dst_alpha_i) * rab_pkg::WeightW'(inv_sa);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      src_wt_q <= src_wt_d;
      dst_wt_q <= dst_wt_d;
      sa_q     <= src_alpha_i;
    end
  end

  // Alpha: sa + floor(da*(255-sa)/255) via reciprocal multiply
  always_comb begin
    dst_prod  = ProdW'(dst_wt_q) * ProdW'(rab_pkg::DivMul);
    alpha_sum = {1'b0, sa_q}
              + {1'b0, dst_prod[rab_pkg::DivShift +: rab_pkg::ChanW]};
    alpha_d   = alpha_sum[rab_pkg::ChanW-1:0];
  end

  // Carry alpha alongside the colour lanes
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_num) begin
      alpha2_q <= alpha_d;
    end
    if (ctl_i.ld_out) begin
      alpha3_q <= alpha2_q;
    end
  end

  assign src_wt_o = src_wt_q;
  assign dst_wt_o = dst_wt_q;
  assign alpha_o  = alpha3_q;

endmodule

`default_nettype wire

### hw/rtl/rab_lane.sv
// One colour lane: weighted sum of source and destination, then divide by 65025.
// Depends on rab_pkg for widths, reciprocal constants and stage_ctl_t.
`default_nettype none

module rab_lane (
  input  wire                          clk_i,
  input  rab_pkg::stage_ctl_t          ctl_i,
  input  wire  [rab_pkg::ChanW-1:0]    src_i,
  input  wire  [rab_pkg::ChanW-1:0]    dst_i,
  input  wire  [rab_pkg::WeightW-1:0]  src_wt_i,
  input  wire  [rab_pkg::WeightW-1:0]  dst_wt_i,
  output logic [rab_pkg::ChanW-1:0]    chan_o
);

  localparam int unsigned SumW  = rab_pkg::NumW + 1;
  localparam int unsigned ProdW = rab_pkg::NumW + rab_pkg::DivSqMulW;

  logic [rab_pkg::ChanW-1:0] src_q, dst_q;
  logic [SumW-1:0]           sum;
  logic [rab_pkg::NumW-1:0]  num_d, num_q;
  logic [ProdW-1:0]          quo_prod;
  logic [rab_pkg::ChanW-1:0] chan_d, chan_q;

  // Hold the channel pair while the weights are formed
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      src_q <= src_i;
      dst_q <= dst_i;
    end
  end

  // Weighted sum, at most 255 * 65025 so it fits the lane width
  always_comb begin
    sum   = SumW'(SumW'(src_q) * SumW'(src_wt_i)) + SumW'(SumW'(dst_q) * SumW'(dst_wt_i));
    num_d = sum[rab_pkg::NumW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_num) begin
      num_q <= num_d;
    end
  end

  // Divide by 65025 through the reciprocal; the quotient never exceeds 255
  always_comb begin
    quo_prod = ProdW'(num_q) * ProdW'(rab_pkg::DivSqMul);
    chan_d   = quo_prod[rab_pkg::DivSqShift +: rab_pkg::ChanW];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_out) begin
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

### hw/rtl/rgba_alpha_blend_pixel.sv
// RGBA alpha blend of one source pixel over one destination pixel.
// Depends on rab_pkg, rab_coef and rab_lane.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with the source and destination
//   BGRA bytes. Output channel: out_valid_o / out_stall_i with the blended
//   BGRA bytes. A beat moves when valid is high and stall is low.
//   Throughput: one pixel per cycle unless out_stall_i holds the pipeline.
//   Three colour lanes and the alpha path run side by side in a three-stage
//   pipeline (weights, weighted sum, reciprocal divide), so every stage holds
//   its own pixel. A result is offered once it has passed the input, sum and
//   output registers in that order.
//   Each stage advances when its successor is empty or moving, so a stalled
//   receiver freezes the output register and the pipeline fills behind it;
//   in_stall_o rises only once all three stages hold pixels.
//   Reset clears the stage valid bits; the pipeline comes up empty and ready.
`default_nettype none

module rgba_alpha_blend_pixel (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire  [rab_pkg::ChanW-1:0]  src_blue_i,
  input  wire  [rab_pkg::ChanW-1:0]  src_green_i,
  input  wire  [rab_pkg::ChanW-1:0]  src_red_i,
  input  wire  [rab_pkg::ChanW-1:0]  src_alpha_i,
  input  wire  [rab_pkg::ChanW-1:0]  dst_blue_i,
  input  wire  [rab_pkg::ChanW-1:0]  dst_green_i,
  input  wire  [rab_pkg::ChanW-1:0]  dst_red_i,
  input  wire  [rab_pkg::ChanW-1:0]  dst_alpha_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [rab_pkg::ChanW-1:0]  out_blue_o,
  output logic [rab_pkg::ChanW-1:0]  out_green_o,
  output logic [rab_pkg::ChanW-1:0]  out_red_o,
  output logic [rab_pkg::ChanW-1:0]  out_alpha_o
);

  logic                        v1_q, v2_q, v3_q;
  logic                        v1_d, v2_d, v3_d;
  logic                        adv1, adv2, adv3;
  rab_pkg::stage_ctl_t         ctl;
  logic [rab_pkg::WeightW-1:0] src_wt, dst_wt;

  // Stage advance: move when the next stage is empty or moving
  always_comb begin
    adv3 = !v3_q || !out_stall_i;
    adv2 = !v2_q || adv3;
    adv1 = !v1_q || adv2;
    ctl.ld_in  = adv1 && in_valid_i;
    ctl.ld_num = adv2 && v1_q;
    ctl.ld_out = adv3 && v2_q;
    v1_d = adv1 ? in_valid_i : v1_q;
    v2_d = adv2 ? v1_q : v2_q;
    v3_d = adv3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Weights and combined alpha
  rab_coef u_coef (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .src_alpha_i (src_alpha_i),
    .dst_alpha_i (dst_alpha_i),
    .src_wt_o    (src_wt),
    .dst_wt_o    (dst_wt),
    .alpha_o     (out_alpha_o)
  );

  // Colour lanes
  rab_lane u_lane_blue (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .src_i    (src_blue_i),
    .dst_i    (dst_blue_i),
    .src_wt_i (src_wt),
    .dst_wt_i (dst_wt),
    .chan_o   (out_blue_o)
  );

  rab_lane u_lane_green (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .src_i    (src_green_i),
    .dst_i    (dst_green_i),
    .src_wt_i (src_wt),
    .dst_wt_i (dst_wt),
    .chan_o   (out_green_o)
  );

  rab_lane u_lane_red (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .src_i    (src_red_i),
    .dst_i    (dst_red_i),
    .src_wt_i (src_wt),
    .dst_wt_i (dst_wt),
    .chan_o   (out_red_o)
  );

  assign in_stall_o  = !adv1;
  assign out_valid_o = v3_q;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for rgba_alpha_blend_pixel: directed corner pixels, then random pixel pairs,
// with random idling on both channels. Results are checked against typed-in values or a local blend model.
// Depends on rab_pkg and the rgba_alpha_blend_pixel RTL.

module testbench;

  typedef logic [rab_pkg::ChanW-1:0] chan_t;

  typedef struct packed {
    chan_t sb, sg, sr, sa;
    chan_t db, dg, dr, da;
  } pixel_pair_t;

  typedef struct packed {
    chan_t b, g, r, a;
  } blended_t;

  // One row of the directed table; the result is typed in only where known offhand
  typedef struct packed {
    pixel_pair_t pix;
    logic        typed;
    blended_t    want;
  } blend_row_t;

  localparam int unsigned FullSq     = rab_pkg::FullVal * rab_pkg::FullVal;
  localparam int          NumRows    = 12;
  localparam int          NumRandom  = 400;
  localparam int          LongHold   = 64;
  localparam int          BurstLen   = 16;
  localparam int          TailCycles = 10;
  localparam int          CycleLimit = 200000;

  localparam blend_row_t DirectedRows [NumRows] = '{
    // all zero: nothing to blend
    '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    // everything at full scale
    '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd255}},
    // opaque source replaces the destination
    '{'{8'd12, 8'd34, 8'd56, 8'd255, 8'd200, 8'd100, 8'd50, 8'd77}, 1'b1,
      '{8'd12, 8'd34, 8'd56, 8'd255}},
    // transparent source over opaque destination keeps the destination
    '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd9, 8'd130, 8'd250, 8'd255}, 1'b1,
      '{8'd9, 8'd130, 8'd250, 8'd255}},
    // both transparent: all channels vanish
    '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd0}},
    // opaque black source over opaque white
    '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd0, 8'd0, 8'd0, 8'd255}},
    // near-extreme alphas and mixed patterns, left to the blend model
    '{'{8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd254}, 1'b0, '0},
    '{'{8'd128, 8'd64, 8'd32, 8'd128, 8'd16, 8'd8, 8'd4, 8'd128}, 1'b0, '0},
    '{'{8'd1, 8'd2, 8'd3, 8'd254, 8'd254, 8'd253, 8'd252, 8'd1}, 1'b0, '0},
    '{'{8'd170, 8'd85, 8'd170, 8'd85, 8'd85, 8'd170, 8'd85, 8'd170}, 1'b0, '0},
    '{'{8'd255, 8'd0, 8'd255, 8'd127, 8'd0, 8'd255, 8'd0, 8'd255}, 1'b0, '0},
    '{'{8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd0, 8'd255, 8'd0}, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  pixel_pair_t in_pix;
  logic        out_stall;
  logic        in_stall;
  logic        out_valid;
  chan_t       out_blue, out_green, out_red, out_alpha;

  blended_t pending_blends [$];
  int       mismatches = 0;
  int       beats_seen = 0;
  int       cycles = 0;
  int       burst_left = 0;
  logic     no_idle = 1'b0;
  logic     hold_out_req = 1'b0;

  rgba_alpha_blend_pixel dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .src_blue_i  (in_pix.sb),
    .src_green_i (in_pix.sg),
    .src_red_i   (in_pix.sr),
    .src_alpha_i (in_pix.sa),
    .dst_blue_i  (in_pix.db),
    .dst_green_i (in_pix.dg),
    .dst_red_i   (in_pix.dr),
    .dst_alpha_i (in_pix.da),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_blue_o  (out_blue),
    .out_green_o (out_green),
    .out_red_o   (out_red),
    .out_alpha_o (out_alpha)
  );

  always #1 clk = ~clk;

  // Colour lane: source weighted by its alpha, destination by both alphas
  function automatic chan_t mix_channel(chan_t s, chan_t sa, chan_t d, chan_t da);
    int unsigned weighted;
    weighted = s * sa * rab_pkg::FullVal + d * da * (rab_pkg::FullVal - sa);
    return chan_t'(weighted / FullSq);
  endfunction

  function automatic blended_t blend_pixel(pixel_pair_t p);
    blended_t    res;
    int unsigned under;
    under = p.da * (rab_pkg::FullVal - p.sa);
    res.b = mix_channel(p.sb, p.sa, p.db, p.da);
    res.g = mix_channel(p.sg, p.sa, p.dg, p.da);
    res.r = mix_channel(p.sr, p.sa, p.dr, p.da);
    res.a = chan_t'(p.sa + under / rab_pkg::FullVal);
    return res;
  endfunction

  // Alphas lean toward the opaque and transparent ends now and then
  function automatic chan_t random_alpha();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return chan_t'($urandom_range(1, 3));
      3: return chan_t'($urandom_range(252, 254));
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    p.sb = chan_t'($urandom_range(0, 255));
    p.sg = chan_t'($urandom_range(0, 255));
    p.sr = chan_t'($urandom_range(0, 255));
    p.sa = random_alpha();
    p.db = chan_t'($urandom_range(0, 255));
    p.dg = chan_t'($urandom_range(0, 255));
    p.dr = chan_t'($urandom_range(0, 255));
    p.da = random_alpha();
    return p;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || burst_left > 0) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_chan(string name, chan_t got, chan_t want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %0d want %0d", beats_seen, name, got, want));
  endtask

  // Offer one pixel pair, hold it until accepted, log the expected blend, then idle for a random gap
  task automatic send_pixel(pixel_pair_t p, logic typed, blended_t want);
    int gap;
    in_valid <= 1'b1;
    in_pix   <= p;
    do @(posedge clk); while (in_stall);
    pending_blends.push_back(typed ? want : blend_pixel(p));
    if (burst_left > 0) burst_left--;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding blend to come back
  task automatic drain_blends();
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        hold_out_req <= 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 99) < 15) begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 29) : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each output beat against the oldest expected blend
  always @(posedge clk) begin
    blended_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blends.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
      end else begin
        want = pending_blends.pop_front();
        check_chan("blue", out_blue, want.b);
        check_chan("green", out_green, want.g);
        check_chan("red", out_red, want.r);
        check_chan("alpha", out_alpha, want.a);
      end
      beats_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_valid <= 1'b0;
    in_pix   <= '0;
    rst_n    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < NumRows; i++)
      send_pixel(DirectedRows[i].pix, DirectedRows[i].typed, DirectedRows[i].want);

    // Random pixel pairs with idle phases, a back-pressure burst and a full drain
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 150) no_idle <= 1'b1;
      if (i == 210) no_idle <= 1'b0;
      if (i == 250) begin
        hold_out_req <= 1'b1;
        burst_left = BurstLen;
      end
      if (i == 320) drain_blends();
      send_pixel(random_pair(), 1'b0, '0);
    end

    drain_blends();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0 && pending_blends.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
